/* rtl/ip_address_text_parser_defines.svh */
// Assertion macros for the IP address text parser.
`ifndef IP_ADDRESS_TEXT_PARSER_DEFINES_SVH
`define IP_ADDRESS_TEXT_PARSER_DEFINES_SVH
// Assert that a condition implies a consequence in the same cycle.
`define IAP_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");
// Assert that a condition implies a consequence in the next cycle.
`define IAP_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* rtl/iap_pkg.sv */
// Package: payload types and constants of the IP address text parser.
`default_nettype none
package iap_pkg;
  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } iap_in_t;

  typedef struct packed {
    logic        valid_res;
    logic        is_ipv6;
    logic [63:0] address_high;
    logic [63:0] address_low;
  } iap_out_t;

  // Character classes from the front end.
  localparam logic [1:0] CLS_HEX   = 2'd0;
  localparam logic [1:0] CLS_COLON = 2'd1;
  localparam logic [1:0] CLS_DOT   = 2'd2;
  localparam logic [1:0] CLS_OTHER = 2'd3;

  // Classified character handed from front to back.
  typedef struct packed {
    logic [1:0] cls;
    logic [3:0] nib;
    logic       pfx_ok;   // character matches mapped prefix at its position
    logic       idx0;
    logic       idx1;
    logic       idx6;
    logic       too_long;
    logic       last;
  } iap_tok_t;

  localparam logic [7:0] MAP_PFX [7] = '{8'h3a, 8'h3a, 8'h66, 8'h66, 8'h66, 8'h66, 8'h3a};
endpackage
`default_nettype wire

/* rtl/iap_front.sv */
// Front end: counts characters per address and classifies each one.
`default_nettype none
module iap_front #(
  parameter int MAX_CHARS = 63
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire iap_pkg::iap_in_t  in_data,
  input  wire logic              in_fire,
  output iap_pkg::iap_tok_t      tok
);
  import iap_pkg::*;
  localparam int CW = $clog2(MAX_CHARS + 2);
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [7:0] c;
  assign c = in_data.character;

  always_comb begin
    tok = '0;
    tok.last = in_data.last;
    if (c inside {[8'h30:8'h39]}) begin
      tok.cls = CLS_HEX;
      tok.nib = 4'(c - 8'h30);
    end else if (c inside {[8'h61:8'h66]}) begin
      tok.cls = CLS_HEX;
      tok.nib = 4'(c - 8'h57);
    end else if (c inside {[8'h41:8'h46]}) begin
      tok.cls = CLS_HEX;
      tok.nib = 4'(c - 8'h37);
    end else if (c == 8'h3a) begin
      tok.cls = CLS_COLON;
    end else if (c == 8'h2e) begin
      tok.cls = CLS_DOT;
    end else begin
      tok.cls = CLS_OTHER;
    end
    tok.idx0 = (cnt_r == CW'(0));
    tok.idx1 = (cnt_r == CW'(1));
    tok.idx6 = (cnt_r == CW'(6));
    tok.pfx_ok = (cnt_r < CW'(7)) && (c == MAP_PFX[cnt_r[2:0]]);
    tok.too_long = (cnt_r >= CW'(MAX_CHARS));
    cnt_nxt = cnt_r;
    if (in_fire) begin
      if (in_data.last) cnt_nxt = '0;
      else if (cnt_r != CW'(MAX_CHARS + 1)) cnt_nxt = cnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else cnt_r <= cnt_nxt;
  end
endmodule
`default_nettype wire

/* rtl/iap_queue.sv */
// Two-entry queue of classified characters between front and back.
`default_nettype none
module iap_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire iap_pkg::iap_tok_t wr_data,
  input  wire logic              wr_en,
  output logic                   full,
  output iap_pkg::iap_tok_t      rd_data,
  output logic                   rd_valid,
  input  wire logic              rd_en
);
  import iap_pkg::*;
  iap_tok_t   mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  assign full = cnt_r[1];
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data = mem_r[rp_r];
  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr_en) - 2'(rd_en);
    end
  end
endmodule
`default_nettype wire

/* rtl/iap_back.sv */
// Back end: field accumulation, group and octet stores, final verdict.
`default_nettype none
module iap_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire iap_pkg::iap_tok_t tok,
  input  wire logic              tok_valid,
  output logic                   tok_take,
  output iap_pkg::iap_out_t      out_data,
  output logic                   out_valid,
  input  wire logic              out_ready
);
  import iap_pkg::*;
  logic [2:0]  mode_r, mode_nxt;
  logic [15:0] fv_r, fv_nxt;
  logic [2:0]  fd_r, fd_nxt;
  logic [15:0] grp_r [8];
  logic [15:0] grp_nxt [8];
  logic [3:0]  gb_r, gb_nxt, ga_r, ga_nxt;
  logic        gap_r, gap_nxt;
  logic [7:0]  oct_r [4];
  logic [7:0]  oct_nxt [4];
  logic [2:0]  oc_r, oc_nxt;
  logic [3:0]  pf_r, pf_nxt;
  logic        err_r, err_nxt;
  iap_out_t    res_r, res_nxt;
  logic        ov_r;
  logic        emit;

  // Only a last character has to wait for the output register to free up.
  assign tok_take = tok_valid && (!tok.last || !ov_r || out_ready);
  assign emit = tok_take && tok.last;
  assign out_valid = ov_r;
  assign out_data = res_r;

  function automatic logic oct_ok(input logic [15:0] fv, input logic [2:0] fd,
                                  output logic [7:0] o);
    logic [3:0] n0, n1, n2;
    logic [9:0] v;
    begin
      n0 = fv[3:0]; n1 = fv[7:4]; n2 = fv[11:8];
      v = 10'(n2) * 10'd100 + 10'(n1) * 10'd10 + 10'(n0);
      o = v[7:0];
      oct_ok = !(fd == 3'd0 || fd > 3'd3 || n0 > 4'd9 || n1 > 4'd9 || n2 > 4'd9 ||
                 (fd == 3'd2 && n1 == 4'd0) || (fd == 3'd3 && n2 == 4'd0) ||
                 v > 10'd255);
    end
  endfunction

  always_comb begin
    logic [1:0]  run;
    logic [1:0]  kind;
    logic [3:0]  tot;
    logic [7:0]  o;
    logic [3:0]  ts;
    logic        valid, v6;
    logic [63:0] hi, lo;
    logic [15:0] g;
    mode_nxt = mode_r; fv_nxt = fv_r; fd_nxt = fd_r; gb_nxt = gb_r; ga_nxt = ga_r;
    gap_nxt = gap_r; oc_nxt = oc_r; pf_nxt = pf_r; err_nxt = err_r;
    grp_nxt = grp_r; oct_nxt = oct_r; res_nxt = res_r;
    run = mode_r[1:0]; kind = 2'd0; o = '0; valid = 1'b0; v6 = 1'b0;
    hi = '0; lo = '0; g = '0; ts = '0;
    tot = gb_r + ga_r;
    if (!tok.pfx_ok) pf_nxt[0] = 1'b0;
    case (tok.cls)
      CLS_HEX: begin
        if (run == 2'd1 && tok.idx1) err_nxt = 1'b1;
        mode_nxt[1:0] = 2'd0;
        fv_nxt = {fv_r[11:0], tok.nib};
        if (fd_r < 3'd5) fd_nxt = fd_r + 3'd1;
      end
      CLS_COLON: begin
        if (pf_r[3]) mode_nxt[2] = 1'b1;
        if (pf_nxt[0] && tok.idx1) kind = 2'd2;
        if (pf_nxt[0] && tok.idx6) kind = 2'd3;
        pf_nxt = {pf_nxt[3], kind, pf_nxt[0]};
        if (fd_r != 3'd0) begin
          if (fd_r > 3'd4 || tot >= 4'd8) err_nxt = 1'b1;
          else begin
            grp_nxt[tot[2:0]] = fv_r;
            if (gap_r) ga_nxt = ga_r + 4'd1;
            else gb_nxt = gb_r + 4'd1;
          end
          run = 2'd1;
        end else if (run == 2'd1) begin
          if (gap_r) err_nxt = 1'b1;
          gap_nxt = 1'b1;
          run = 2'd2;
        end else if (run == 2'd0 && tok.idx0) begin
          run = 2'd1;
        end else begin
          err_nxt = 1'b1;
        end
        mode_nxt[1:0] = run;
        fv_nxt = '0; fd_nxt = '0;
      end
      CLS_DOT: begin
        if (oc_r >= 3'd3 || !oct_ok(fv_r, fd_r, o)) mode_nxt[2] = 1'b1;
        else begin
          oct_nxt[oc_r[1:0]] = o;
          oc_nxt = oc_r + 3'd1;
        end
        pf_nxt[3] = 1'b1;
        mode_nxt[1:0] = 2'd0;
        fv_nxt = '0; fd_nxt = '0;
      end
      default: begin
        err_nxt = 1'b1;
        mode_nxt[2] = 1'b1;
      end
    endcase

    // Verdict on the final character, from the updated state.
    if (pf_nxt[3]) begin
      if (oc_nxt == 3'd3 && oct_ok(fv_nxt, fd_nxt, o) && !mode_nxt[2] &&
          pf_nxt[2:1] != 2'd0) begin
        valid = 1'b1;
        v6 = (pf_nxt[2:1] != 2'd1);
        lo = {32'd0, oct_nxt[0], oct_nxt[1], oct_nxt[2], o};
        if (pf_nxt[2:1] == 2'd3) lo[47:32] = 16'hffff;
      end
    end else begin
      logic [15:0]  gs [8];
      logic [3:0]   b, a;
      logic         e;
      logic [127:0] ad;
      gs = grp_nxt; b = gb_nxt; a = ga_nxt; e = err_nxt; ad = '0;
      tot = gb_nxt + ga_nxt;
      if (fd_nxt != 3'd0) begin
        if (fd_nxt > 3'd4 || tot >= 4'd8) e = 1'b1;
        else begin
          gs[tot[2:0]] = fv_nxt;
          if (gap_nxt) a = a + 4'd1;
          else b = b + 4'd1;
        end
      end else if (mode_nxt[1:0] != 2'd2) e = 1'b1;
      tot = b + a;
      if (!e && (gap_nxt ? tot <= 4'd7 : b == 4'd8)) begin
        valid = 1'b1;
        v6 = 1'b1;
        ts = 4'd8 - a;
        for (int i = 0; i < 8; i++) begin
          g = '0;
          if (4'(i) < b) g = gs[i];
          else if (4'(i) >= ts) g = gs[3'(b + 4'(i) - ts)];
          ad[16*(7-i) +: 16] = g;
        end
        hi = ad[127:64];
        lo = ad[63:0];
      end
    end
    if (tok.too_long) valid = 1'b0;
    res_nxt.valid_res = valid;
    res_nxt.is_ipv6 = valid & v6;
    res_nxt.address_high = valid ? hi : 64'd0;
    res_nxt.address_low = valid ? lo : 64'd0;
  end

  always_ff @(posedge clk) begin
    if (emit) res_r <= res_nxt;
    if (tok_take && !tok.last) oct_r <= oct_nxt;
    if (!rst_n || emit) begin
      mode_r <= '0; fv_r <= '0; fd_r <= '0; gb_r <= '0; ga_r <= '0; gap_r <= 1'b0;
      oc_r <= '0; pf_r <= 4'h3; err_r <= 1'b0;
      for (int i = 0; i < 8; i++) grp_r[i] <= '0;
    end else if (tok_take) begin
      mode_r <= mode_nxt; fv_r <= fv_nxt; fd_r <= fd_nxt; gb_r <= gb_nxt;
      ga_r <= ga_nxt; gap_r <= gap_nxt; oc_r <= oc_nxt; pf_r <= pf_nxt;
      err_r <= err_nxt; grp_r <= grp_nxt;
    end
    if (!rst_n) ov_r <= 1'b0;
    else if (emit) ov_r <= 1'b1;
    else if (out_ready) ov_r <= 1'b0;
  end
endmodule
`default_nettype wire

/* rtl/ip_address_text_parser.sv */
// Top level of the IP address text parser.
`default_nettype none
// Takes an IPv4 or IPv6 address as text, one ASCII character per transfer, and
// gives one verdict transfer after the character flagged last: valid_res, the
// family and the 128-bit address (IPv4 in bits 31:0 of address_low; mapped
// and compatible dotted tails as IPv6). Throughput is one character per cycle
// while in_ready is high; a character passes the front end (counter and
// classifier) into a two-entry queue and is folded into the parse state by
// the back end, and a last character taken from the queue sets the output
// register that drives out_valid. The output register holds a verdict while
// the next address streams in; the back end stalls only when a last character
// reaches it while the previous verdict is still untaken, and in_ready falls
// once the queue behind it holds two characters.
// Texts longer than MAX_CHARS are rejected.
module ip_address_text_parser #(
  parameter int MAX_CHARS = 63
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire iap_pkg::iap_in_t  in_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output iap_pkg::iap_out_t      out_data,
  output logic                   out_valid,
  input  wire logic              out_ready
);
  import iap_pkg::*;
  `include "ip_address_text_parser_defines.svh"

  iap_tok_t tok_w, tok_q;
  logic     q_full, q_valid, q_take, in_fire;

  assign in_ready = !q_full;
  assign in_fire = in_valid && in_ready;

  iap_front #(.MAX_CHARS(MAX_CHARS)) u_front (
    .clk(clk), .rst_n(rst_n), .in_data(in_data), .in_fire(in_fire), .tok(tok_w)
  );

  iap_queue u_queue (
    .clk(clk), .rst_n(rst_n), .wr_data(tok_w), .wr_en(in_fire), .full(q_full),
    .rd_data(tok_q), .rd_valid(q_valid), .rd_en(q_take)
  );

  iap_back u_back (
    .clk(clk), .rst_n(rst_n), .tok(tok_q), .tok_valid(q_valid), .tok_take(q_take),
    .out_data(out_data), .out_valid(out_valid), .out_ready(out_ready)
  );

  // A verdict never claims IPv6 without being valid.
  `IAP_ASSERT_IMP(a_v6_valid, clk, rst_n, out_valid && out_data.is_ipv6, out_data.valid_res)
  // A last character taken by the back end raises the result the next cycle.
  `IAP_ASSERT_NEXT(a_emit, clk, rst_n, q_take && tok_q.last, out_valid)
  // Queue never accepts while full.
  `IAP_ASSERT_IMP(a_noovf, clk, rst_n, q_full, !in_ready)
endmodule
`default_nettype wire
